FILE: design/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under clock and active-low reset
`define GTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent followed in the next cycle by consequent
`define GTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/gta_pkg.sv
// Types, constants and the GF(2^128) digit step of the GHASH tag accumulator
package gta_pkg;

  localparam int unsigned GfBits     = 128;
  localparam int unsigned DigitBits  = 16;
  localparam int unsigned DigitSteps = GfBits / DigitBits;
  localparam int unsigned StepCntW   = $clog2(DigitSteps);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CountW     = 5;
  localparam logic [63:0] GfReduce   = 64'hE100000000000000;
  localparam logic [CountW-1:0] FullBlock = CountW'(16);

  localparam logic [CfgIdxW-1:0] CfgHashKeyHi = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHashKeyLo = 1'b1;

  typedef struct packed {
    logic [63:0]       data_hi;
    logic [63:0]       data_lo;
    logic [CountW-1:0] byte_count;
    logic              last_block;
    logic [63:0]       tag_mask_hi;
    logic [63:0]       tag_mask_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
    logic        length_overflow;
  } out_t;

  typedef struct packed {
    logic [GfBits-1:0] z;
    logic [GfBits-1:0] v;
  } gf_state_t;

  // One digit of the bit-serial GCM multiply, most significant operand bit first
  function automatic gf_state_t gf_digit(gf_state_t s, logic [DigitBits-1:0] bits);
    gf_state_t r;
    logic      carry;
    r = s;
    for (int i = 0; i < DigitBits; i++) begin
      if (bits[DigitBits-1-i]) begin
        r.z = r.z ^ r.v;
      end
      carry = r.v[0];
      r.v   = r.v >> 1;
      if (carry) begin
        r.v[GfBits-1 -: 64] = r.v[GfBits-1 -: 64] ^ GfReduce;
      end
    end
    return r;
  endfunction

endpackage

FILE: design/ghash_tag_accumulator_core.sv
// GHASH tag accumulator: masked block absorb, iterative GF(2^128) multiply, tag output
// A data block with a non-zero byte count is accepted while the block is idle and then multiplied by
// the hash key, 16 accumulator bits per cycle through one shared GF digit unit. A last
// item adds a second multiply for the length block and then loads the tag register; with
// a zero byte count it does only the length multiply and the load. A block with zero
// bytes that is not last is absorbed in its accept cycle. The input stalls while the
// multiply runs and while a finished tag waits for the previous tag to be taken; the tag
// register is separate, so a waiting tag holds back the next message only once its tag
// is ready.
module ghash_tag_accumulator_core #(
  parameter int unsigned TOTAL_BYTES_BITS = 36
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gta_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gta_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gta_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);

  localparam int unsigned GfBits = gta_pkg::GfBits;
  localparam int unsigned StW    = 2;
  localparam logic [StW-1:0] StIdle = 2'd0;
  localparam logic [StW-1:0] StMul  = 2'd1;
  localparam logic [StW-1:0] StEmit = 2'd2;
  localparam logic [TOTAL_BYTES_BITS-1:0] TotalMax = {TOTAL_BYTES_BITS{1'b1}};

  logic [StW-1:0]                  state_q, state_d;
  logic [gta_pkg::StepCntW-1:0]    cnt_q, cnt_d;
  logic [GfBits-1:0]               h_q, h_d;
  logic [GfBits-1:0]               acc_q, acc_d;
  logic [TOTAL_BYTES_BITS-1:0]     total_q, total_d;
  logic                            ovf_q, ovf_d;
  logic                            last_q, last_d;
  logic                            len_phase_q, len_phase_d;
  logic                            out_valid_q, out_valid_d;
  gta_pkg::gf_state_t              gf_q, gf_d, step;
  logic [GfBits-1:0]               mask_q, mask_d;
  gta_pkg::out_t                   out_q, out_d;

  logic                            in_acc;
  logic [gta_pkg::CountW-1:0]      n;
  logic [GfBits-1:0]               keep;
  logic [GfBits-1:0]               blk;
  logic [TOTAL_BYTES_BITS:0]       sum;
  logic [63:0]                     len_now;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign n = (in_data_i.byte_count > gta_pkg::FullBlock) ? gta_pkg::FullBlock
                                                         : in_data_i.byte_count;
  assign keep    = ~({GfBits{1'b1}} >> {n, 3'b000});
  assign blk     = {in_data_i.data_hi, in_data_i.data_lo} & keep;
  assign sum     = {1'b0, total_q} + (TOTAL_BYTES_BITS + 1)'(n);
  assign len_now = 64'(total_q) << 3;
  assign step    = gta_pkg::gf_digit(gf_q, acc_q[GfBits-1 -: gta_pkg::DigitBits]);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    h_d         = h_q;
    acc_d       = acc_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    len_phase_d = len_phase_q;
    gf_d        = gf_q;
    mask_d      = mask_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gta_pkg::CfgHashKeyHi: h_d[GfBits-1 -: 64] = cfg_data_i;
        gta_pkg::CfgHashKeyLo: h_d[63:0]           = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          last_d = in_data_i.last_block;
          mask_d = {in_data_i.tag_mask_hi, in_data_i.tag_mask_lo};
          gf_d.z = '0;
          gf_d.v = h_q;
          cnt_d  = '0;
          if (n != '0) begin
            acc_d       = acc_q ^ blk;
            len_phase_d = 1'b0;
            state_d     = StMul;
            if (sum[TOTAL_BYTES_BITS]) begin
              total_d = TotalMax;
              ovf_d   = 1'b1;
            end else begin
              total_d = sum[TOTAL_BYTES_BITS-1:0];
            end
          end else if (in_data_i.last_block) begin
            acc_d       = acc_q ^ {64'd0, len_now};
            len_phase_d = 1'b1;
            state_d     = StMul;
          end
        end
      end
      StMul: begin
        acc_d = acc_q << gta_pkg::DigitBits;
        gf_d  = step;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == gta_pkg::StepCntW'(gta_pkg::DigitSteps - 1)) begin
          if (len_phase_q) begin
            gf_d.z  = step.z ^ mask_q;
            acc_d   = '0;
            total_d = '0;
            state_d = StEmit;
          end else if (last_q) begin
            acc_d       = step.z ^ {64'd0, len_now};
            gf_d.z      = '0;
            gf_d.v      = h_q;
            cnt_d       = '0;
            len_phase_d = 1'b1;
          end else begin
            acc_d   = step.z;
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.tag_hi          = gf_q.z[GfBits-1 -: 64];
          out_d.tag_lo          = gf_q.z[63:0];
          out_d.length_overflow = ovf_q;
          out_valid_d           = 1'b1;
          state_d               = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      h_q         <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      len_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      h_q         <= h_d;
      acc_q       <= acc_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      len_phase_q <= len_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gf_q   <= gf_d;
    mask_q <= mask_d;
    out_q  <= out_d;
  end

endmodule

FILE: design/gta_checker.sv
// Port-level checker for the GHASH tag accumulator and its bind
`include "assert_macros.svh"

module gta_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input gta_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gta_pkg::out_t out_data_o
);

  `GTA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "tag request dropped while stalled")
  `GTA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "stalled tag changed")
  `GTA_ASSERT_NEXT(a_busy_after_work, clk_i, rst_ni, in_valid_i && !in_stall_o && ((in_data_i.byte_count != 5'd0) || in_data_i.last_block), in_stall_o, "block not busy after accepting work")
  `GTA_ASSERT(a_tag_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "tag appeared without a multiply")

endmodule

bind ghash_tag_accumulator_core gta_checker u_gta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
